FILE: rtl/core/dgfm_pkg.sv
package dgfm_pkg;

   localparam int unsigned DistWidth  = 16;
   localparam int unsigned CountWidth = 20;
   localparam int unsigned CmdWidth   = 2;
   localparam int unsigned IndexWidth = 3;
   localparam int unsigned RspWidth   = 40;

   localparam logic [CmdWidth-1:0] CMD_SAMPLE   = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_TICK     = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_EXIT     = 2'd2;
   localparam logic [CmdWidth-1:0] CMD_COOLDOWN = 2'd3;

   localparam logic [IndexWidth-1:0] REG_MIN_DISTANCE = 3'd0;
   localparam logic [IndexWidth-1:0] REG_MAX_DISTANCE = 3'd1;
   localparam logic [IndexWidth-1:0] REG_FAST_DELTA   = 3'd2;
   localparam logic [IndexWidth-1:0] REG_FAST_HOLD    = 3'd3;
   localparam logic [IndexWidth-1:0] REG_FRESH_WINDOW = 3'd4;
   localparam logic [IndexWidth-1:0] REG_FAST_POLL    = 3'd5;
   localparam logic [IndexWidth-1:0] REG_BASE_POLL    = 3'd6;
   localparam logic [IndexWidth-1:0] REG_COOLDOWN     = 3'd7;

   typedef struct packed {
      logic [DistWidth-1:0]  min_distance_mm;
      logic [DistWidth-1:0]  max_distance_mm;
      logic [DistWidth-1:0]  fast_delta_mm;
      logic [CountWidth-1:0] fast_hold_ms;
      logic [CountWidth-1:0] fresh_window_ms;
      logic [DistWidth-1:0]  fast_poll_ms;
      logic [DistWidth-1:0]  base_poll_ms;
      logic [CountWidth-1:0] cooldown_ms;
   } cfg_type;

   typedef struct packed {
      logic                 cooldown_granted;
      logic [DistWidth-1:0] poll_interval_ms;
      logic                 fast_mode;
      logic                 distance_fresh;
      logic [DistWidth-1:0] distance_mm;
      logic                 accepted;
   } result_type;

endpackage

FILE: rtl/core/distance_gate_fast_mode_tracker.sv
// Distance gate and fast-mode tracker. Each request (sample, 1 ms tick, exit fast
// mode, cooldown request) yields exactly one response showing the state after it.
// Requests pass through an input register, gate/countdown logic and a response
// register: one request per cycle while rsp_tready is high, and the input keeps
// accepting while a response waits for rsp_tready if the input register is free.
// Registers must be written through csr_* only while idle (block does not check).
module distance_gate_fast_mode_tracker
   import dgfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DistWidth-1:0]  req_tdata,   // sample_mm
   input  logic [2:0]            req_tuser,   // command[1:0], sample_bad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RspWidth-1:0]   rsp_tdata,   // accepted, distance_mm[15:0],
                                              // distance_fresh, fast_mode,
                                              // poll_interval_ms[15:0],
                                              // cooldown_granted, zero pad[3:0]
   input  logic                  csr_we,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [CountWidth-1:0] csr_wdata
);

   cfg_type              cfg;
   result_type           result;
   logic                 in_valid_ff, in_valid_in;
   logic [CmdWidth-1:0]  in_cmd_ff;
   logic [DistWidth-1:0] in_mm_ff;
   logic                 in_bad_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff;
   logic                 advance;
   logic                 req_fire;
   logic                 core_fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign core_fire  = in_valid_ff && advance;

   assign in_valid_in  = req_fire ? 1'b1 : (core_fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = core_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   dgfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dgfm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (core_fire),
      .command    (in_cmd_ff),
      .sample_mm  (in_mm_ff),
      .sample_bad (in_bad_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff <= req_tuser[CmdWidth-1:0];
         in_bad_ff <= req_tuser[CmdWidth];
         in_mm_ff  <= req_tdata;
      end
      if (core_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RspWidth - $bits(result_type))'(0), rsp_ff};

endmodule

FILE: rtl/core/dgfm_csr.sv
module dgfm_csr
   import dgfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [CountWidth-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MIN_DISTANCE: cfg_in.min_distance_mm = csr_wdata[DistWidth-1:0];
            REG_MAX_DISTANCE: cfg_in.max_distance_mm = csr_wdata[DistWidth-1:0];
            REG_FAST_DELTA:   cfg_in.fast_delta_mm   = csr_wdata[DistWidth-1:0];
            REG_FAST_HOLD:    cfg_in.fast_hold_ms    = csr_wdata;
            REG_FRESH_WINDOW: cfg_in.fresh_window_ms = csr_wdata;
            REG_FAST_POLL:    cfg_in.fast_poll_ms    = csr_wdata[DistWidth-1:0];
            REG_BASE_POLL:    cfg_in.base_poll_ms    = csr_wdata[DistWidth-1:0];
            REG_COOLDOWN:     cfg_in.cooldown_ms     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_distance_mm <= DistWidth'(40);
         cfg_ff.max_distance_mm <= DistWidth'(3600);
         cfg_ff.fast_delta_mm   <= DistWidth'(100);
         cfg_ff.fast_hold_ms    <= CountWidth'(5000);
         cfg_ff.fresh_window_ms <= CountWidth'(1000);
         cfg_ff.fast_poll_ms    <= DistWidth'(50);
         cfg_ff.base_poll_ms    <= DistWidth'(500);
         cfg_ff.cooldown_ms     <= CountWidth'(10000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/dgfm_core.sv
module dgfm_core
   import dgfm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [CmdWidth-1:0]  command,
   input  logic [DistWidth-1:0] sample_mm,
   input  logic                 sample_bad,
   input  cfg_type              cfg,
   output result_type           result
);

   typedef struct packed {
      logic                  flag;
      logic [CountWidth-1:0] count;
   } countdown_type;

   function automatic countdown_type run_countdown(countdown_type cur);
      countdown_type nxt;
      nxt = cur;
      if (cur.flag) begin
         if (cur.count == '0) begin
            nxt.flag = 1'b0;
         end else begin
            nxt.count = cur.count - CountWidth'(1);
            if (nxt.count == '0) begin
               nxt.flag = 1'b0;
            end
         end
      end
      return nxt;
   endfunction

   logic [DistWidth-1:0] previous_mm_ff, previous_mm_in;
   logic                 have_previous_ff, have_previous_in;
   logic [DistWidth-1:0] last_mm_ff, last_mm_in;
   logic                 have_distance_ff, have_distance_in;
   countdown_type        fresh_ff, fresh_in;
   countdown_type        fast_ff, fast_in;
   countdown_type        cool_ff, cool_in;

   logic                 in_range;
   logic                 take;
   logic [DistWidth-1:0] diff;
   logic                 granted;

   assign in_range = !sample_bad && (sample_mm >= cfg.min_distance_mm)
                     && (sample_mm <= cfg.max_distance_mm);
   assign diff     = (sample_mm >= previous_mm_ff) ? (sample_mm - previous_mm_ff)
                                                   : (previous_mm_ff - sample_mm);

   always_comb begin
      previous_mm_in   = previous_mm_ff;
      have_previous_in = have_previous_ff;
      last_mm_in       = last_mm_ff;
      have_distance_in = have_distance_ff;
      fresh_in         = fresh_ff;
      fast_in          = fast_ff;
      cool_in          = cool_ff;
      take             = 1'b0;
      granted          = 1'b0;
      unique case (command)
         CMD_SAMPLE: begin
            if (in_range) begin
               take = 1'b1;
               if (have_previous_ff && (diff >= cfg.fast_delta_mm)) begin
                  fast_in.flag  = 1'b1;
                  fast_in.count = cfg.fast_hold_ms;
               end
               previous_mm_in   = sample_mm;
               have_previous_in = 1'b1;
               last_mm_in       = sample_mm;
               have_distance_in = 1'b1;
               fresh_in.flag    = 1'b1;
               fresh_in.count   = cfg.fresh_window_ms;
            end
         end
         CMD_TICK: begin
            fast_in  = run_countdown(fast_ff);
            fresh_in = run_countdown(fresh_ff);
            cool_in  = run_countdown(cool_ff);
         end
         CMD_EXIT: begin
            fast_in.flag  = 1'b0;
            fast_in.count = '0;
         end
         CMD_COOLDOWN: begin
            if (!cool_ff.flag) begin
               cool_in.flag  = 1'b1;
               cool_in.count = cfg.cooldown_ms;
               granted       = 1'b1;
            end
         end
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      result.accepted         = take;
      result.distance_mm      = last_mm_in;
      result.distance_fresh   = have_distance_in && fresh_in.flag;
      result.fast_mode        = fast_in.flag;
      result.poll_interval_ms = fast_in.flag ? cfg.fast_poll_ms : cfg.base_poll_ms;
      result.cooldown_granted = granted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_mm_ff   <= '0;
         have_previous_ff <= 1'b0;
         last_mm_ff       <= '0;
         have_distance_ff <= 1'b0;
         fresh_ff         <= '0;
         fast_ff          <= '0;
         cool_ff          <= '0;
      end else if (fire) begin
         previous_mm_ff   <= previous_mm_in;
         have_previous_ff <= have_previous_in;
         last_mm_ff       <= last_mm_in;
         have_distance_ff <= have_distance_in;
         fresh_ff         <= fresh_in;
         fast_ff          <= fast_in;
         cool_ff          <= cool_in;
      end
   end

endmodule
